FILE: hw/rtl/brt_pkg.sv
// ----------------------------------------------------------------------------
// brt_pkg
// Shared widths, codes, token and write-command types, residency transitions.
// ----------------------------------------------------------------------------
package brt_pkg;

  localparam int BRT_ENTRIES = 64;

  localparam int KIND_W  = 3;
  localparam int KEY_W   = 64;
  localparam int RES_W   = 2;
  localparam int STAMP_W = 32;
  localparam int HITS_W  = 32;
  localparam int STS_W   = 2;

  // request kinds
  localparam logic [KIND_W-1:0] KIND_REGISTER   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_UNREGISTER = 3'd1;
  localparam logic [KIND_W-1:0] KIND_PROMOTE    = 3'd2;
  localparam logic [KIND_W-1:0] KIND_DEMOTE     = 3'd3;
  localparam logic [KIND_W-1:0] KIND_RES_QUERY  = 3'd4;
  localparam logic [KIND_W-1:0] KIND_TOUCH      = 3'd5;
  localparam logic [KIND_W-1:0] KIND_INFO_QUERY = 3'd6;

  // residency codes
  localparam logic [RES_W-1:0] RES_DISK = 2'd0;
  localparam logic [RES_W-1:0] RES_CPU  = 2'd1;
  localparam logic [RES_W-1:0] RES_GPU  = 2'd2;
  localparam logic [RES_W-1:0] RES_BOTH = 2'd3;

  // result status codes
  localparam logic [STS_W-1:0] STS_OK   = 2'd0;
  localparam logic [STS_W-1:0] STS_MISS = 2'd1;
  localparam logic [STS_W-1:0] STS_FULL = 2'd2;

  // search token walking down the cell row
  typedef struct packed {
    logic               vld;
    logic [KEY_W-1:0]   key;
    logic               hit;
    logic               free;
    logic [RES_W-1:0]   where;
    logic [STAMP_W-1:0] stamp;
    logic [HITS_W-1:0]  hits;
  } tok_t;

  // write command broadcast to all cells; the marked cell takes it
  typedef struct packed {
    logic               en;
    logic               to_hit;
    logic               set_valid;
    logic [KEY_W-1:0]   key;
    logic [RES_W-1:0]   where;
    logic [STAMP_W-1:0] stamp;
    logic [HITS_W-1:0]  hits;
  } wr_cmd_t;

  function automatic logic [RES_W-1:0] promote_to(input logic [RES_W-1:0] r,
                                                  input logic to_gpu);
    logic [RES_W-1:0] n;
    n = r;
    if (to_gpu) begin
      if (r == RES_CPU) n = RES_BOTH;
      else if (r == RES_DISK) n = RES_GPU;
    end else begin
      if (r == RES_DISK) n = RES_CPU;
      else if (r == RES_GPU) n = RES_BOTH;
    end
    return n;
  endfunction

  function automatic logic [RES_W-1:0] demote_from(input logic [RES_W-1:0] r,
                                                   input logic from_gpu);
    logic [RES_W-1:0] n;
    n = r;
    if (from_gpu) begin
      if (r == RES_BOTH) n = RES_CPU;
      else if (r == RES_GPU) n = RES_DISK;
    end else begin
      if (r == RES_BOTH) n = RES_GPU;
      else if (r == RES_CPU) n = RES_DISK;
    end
    return n;
  endfunction

endpackage

FILE: hw/rtl/brt_if.sv
// ----------------------------------------------------------------------------
// brt_if
// Request and result channel interfaces with valid/ready handshake.
// ----------------------------------------------------------------------------
interface brt_in_if import brt_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  kind;
  logic [KEY_W-1:0]   block_id;
  logic [RES_W-1:0]   initial_residency;
  logic               location;
  logic [STAMP_W-1:0] now_stamp;

  modport source(output valid, kind, block_id, initial_residency, location, now_stamp,
                 input ready);
  modport sink(input valid, kind, block_id, initial_residency, location, now_stamp,
               output ready);
endinterface

interface brt_out_if import brt_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [STS_W-1:0]   status;
  logic [RES_W-1:0]   residency;
  logic [STAMP_W-1:0] last_stamp;
  logic [HITS_W-1:0]  hit_count;

  modport source(output valid, status, residency, last_stamp, hit_count,
                 input ready);
  modport sink(input valid, status, residency, last_stamp, hit_count,
               output ready);
endinterface

FILE: hw/rtl/brt_cell.sv
// ----------------------------------------------------------------------------
// brt_cell
// One table slot: compares the passing token, marks itself, takes writes.
// ----------------------------------------------------------------------------
module brt_cell import brt_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  tok_t    tok_in,
  output tok_t    tok_out,
  input  wr_cmd_t cmd
);

  logic               valid_r;
  logic [KEY_W-1:0]   key_r;
  logic [RES_W-1:0]   where_r;
  logic [STAMP_W-1:0] stamp_r;
  logic [HITS_W-1:0]  hits_r;
  logic               hit_mark_r;
  logic               free_mark_r;
  tok_t               tok_r;
  tok_t               tok_nxt;
  logic               match;
  logic               avail;
  logic               wr;

  // first matching slot and first free slot claim the token
  assign match = tok_in.vld && valid_r && (key_r == tok_in.key) && !tok_in.hit;
  assign avail = tok_in.vld && !valid_r && !tok_in.free;
  assign wr    = cmd.en && (cmd.to_hit ? hit_mark_r : free_mark_r);

  always_comb begin
    tok_nxt      = tok_in;
    tok_nxt.hit  = tok_in.hit | match;
    tok_nxt.free = tok_in.free | avail;
    if (match) begin
      tok_nxt.where = where_r;
      tok_nxt.stamp = stamp_r;
      tok_nxt.hits  = hits_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= 1'b0;
      hit_mark_r  <= 1'b0;
      free_mark_r <= 1'b0;
      tok_r       <= '0;
    end else begin
      tok_r <= tok_nxt;
      if (tok_in.vld) begin
        hit_mark_r  <= match;
        free_mark_r <= avail;
      end
      if (wr) begin
        valid_r <= cmd.set_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr && cmd.set_valid) begin
      key_r   <= cmd.key;
      where_r <= cmd.where;
      stamp_r <= cmd.stamp;
      hits_r  <= cmd.hits;
    end
  end

  assign tok_out = tok_r;

endmodule

FILE: hw/rtl/block_residency_table_top.sv
// The search token walks the row of slot cells one cell per cycle and is
//   captured in the tail register; the finish step then writes the marked cell
//   and the output register, once that register is free or being drained.
// A finished result waits in the output register while the next request enters.
// Reset: synchronous, active low; clears all slot valid bits at once, so the
//   table is ready right after reset with no clearing pass.
// ----------------------------------------------------------------------------
// block_residency_table_top
// Associative block-id table built as a row of slot cells with a walking token.
// ----------------------------------------------------------------------------
module block_residency_table_top import brt_pkg::*; #(
  parameter int ENTRIES = BRT_ENTRIES
) (
  input logic      clk,
  input logic      rst_n,
  brt_in_if.sink   in_ch,
  brt_out_if.source out_ch
);

  // controller states
  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SEARCH = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  // held request fields
  logic [KIND_W-1:0]  kind_r;
  logic [RES_W-1:0]   init_r;
  logic               loc_r;
  logic [STAMP_W-1:0] now_r;

  // token captured off the tail of the row
  tok_t tail_r;

  // output register
  logic               out_valid_r;
  logic [STS_W-1:0]   out_status_r;
  logic [RES_W-1:0]   out_res_r;
  logic [STAMP_W-1:0] out_stamp_r;
  logic [HITS_W-1:0]  out_hits_r;

  tok_t    tok_chain [ENTRIES+1];
  tok_t    head_tok;
  wr_cmd_t cmd;
  logic    in_acc;
  logic    fin_go;

  logic [STS_W-1:0]   res_status;
  logic [RES_W-1:0]   res_where;
  logic [STAMP_W-1:0] res_stamp;
  logic [HITS_W-1:0]  res_hits;

  // ---------------------------------------------------------------------------
  // Handshake. Take a request only when the row is quiet; the output register
  // may still hold the previous result.
  // ---------------------------------------------------------------------------
  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  // finish when the output register is free or being drained this cycle
  assign fin_go      = (state_r == ST_FINISH) && (!out_valid_r || out_ch.ready);

  // Inject a fresh token at the head of the row on accept.
  always_comb begin
    head_tok     = '0;
    head_tok.vld = in_acc;
    head_tok.key = in_ch.block_id;
  end

  assign tok_chain[0] = head_tok;

  // ---------------------------------------------------------------------------
  // Row of slot cells. Each cell compares the token against its slot, marks
  // itself as the hit or the first free slot, and passes the token on.
  // ---------------------------------------------------------------------------
  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    brt_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .tok_in  (tok_chain[i]),
      .tok_out (tok_chain[i+1]),
      .cmd     (cmd)
    );
  end

  // ---------------------------------------------------------------------------
  // Finish: build the new entry from the captured token and the held request,
  // broadcast the write to the marked cell, and form the result.
  // ---------------------------------------------------------------------------
  always_comb begin
    cmd        = '0;
    cmd.key    = tail_r.key;
    cmd.where  = tail_r.where;
    cmd.stamp  = tail_r.stamp;
    cmd.hits   = tail_r.hits;
    res_status = STS_MISS;
    res_where  = RES_DISK;
    res_stamp  = '0;
    res_hits   = '0;
    if (kind_r == KIND_REGISTER) begin
      if (tail_r.hit || tail_r.free) begin
        // overwrite the hit, else fill the lowest free slot
        cmd.en        = fin_go;
        cmd.to_hit    = tail_r.hit;
        cmd.set_valid = 1'b1;
        cmd.where     = init_r;
        cmd.stamp     = now_r;
        cmd.hits      = '0;
        res_status    = STS_OK;
        res_where     = init_r;
        res_stamp     = now_r;
      end else begin
        res_status = STS_FULL;
      end
    end else if (tail_r.hit) begin
      res_status = STS_OK;
      res_where  = tail_r.where;
      res_stamp  = tail_r.stamp;
      res_hits   = tail_r.hits;
      cmd.to_hit = 1'b1;
      case (kind_r)
        KIND_UNREGISTER: begin
          // free the slot; report an empty entry
          cmd.en        = fin_go;
          cmd.set_valid = 1'b0;
          res_where     = RES_DISK;
          res_stamp     = '0;
          res_hits      = '0;
        end
        KIND_PROMOTE: begin
          cmd.en        = fin_go;
          cmd.set_valid = 1'b1;
          cmd.where     = promote_to(tail_r.where, loc_r);
          res_where     = cmd.where;
        end
        KIND_DEMOTE: begin
          cmd.en        = fin_go;
          cmd.set_valid = 1'b1;
          cmd.where     = demote_from(tail_r.where, loc_r);
          res_where     = cmd.where;
        end
        KIND_TOUCH: begin
          // stamp and saturating count
          cmd.en        = fin_go;
          cmd.set_valid = 1'b1;
          cmd.stamp     = now_r;
          cmd.hits      = (tail_r.hits == '1) ? tail_r.hits : tail_r.hits + 1'b1;
          res_stamp     = cmd.stamp;
          res_hits      = cmd.hits;
        end
        default: begin
          // residency query, info query and the unused kind change nothing
          cmd.en = 1'b0;
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Control sequencing
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (in_acc) state_nxt = ST_SEARCH;
      ST_SEARCH: if (tok_chain[ENTRIES].vld) state_nxt = ST_FINISH;
      ST_FINISH: if (fin_go) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (fin_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Hold request fields, tail token and result payload.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      kind_r <= in_ch.kind;
      init_r <= in_ch.initial_residency;
      loc_r  <= in_ch.location;
      now_r  <= in_ch.now_stamp;
    end
    if (tok_chain[ENTRIES].vld) begin
      tail_r <= tok_chain[ENTRIES];
    end
    if (fin_go) begin
      out_status_r <= res_status;
      out_res_r    <= res_where;
      out_stamp_r  <= res_stamp;
      out_hits_r   <= res_hits;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.status     = out_status_r;
  assign out_ch.residency  = out_res_r;
  assign out_ch.last_stamp = out_stamp_r;
  assign out_ch.hit_count  = out_hits_r;

`ifndef NO_ASSERTIONS
  // an accepted request starts a search on the next cycle
  a_acc_search: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == ST_SEARCH))
    else $error("accepted request did not start a search");

  // the token reaches the tail only during a search
  a_tail_search: assert property (@(posedge clk) disable iff (!rst_n)
    tok_chain[ENTRIES].vld |-> (state_r == ST_SEARCH))
    else $error("token left the row outside a search");

  // a result appears only after a finish step
  a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(fin_go))
    else $error("result raised without a finish step");

  // writes to the table happen only on a finish step
  a_wr_fin: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.en |-> fin_go)
    else $error("table write outside a finish step");
`endif

endmodule

FILE: bench/block_residency_table_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// block_residency_table_top_tb
// Self-checking bench for the block residency table. Requests go in over the
// request channel. Each accepted request is applied to a local copy of the
// table, which predicts the one result it must produce. Results are matched
// in order, field by field. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module block_residency_table_top_tb;
  import brt_pkg::*;

  // Kind 7 has no name in the package; the block treats it as an info query.
  localparam logic [KIND_W-1:0] KIND_SPARE = 3'd7;

  localparam logic [KEY_W-1:0] ID_ZERO = '0;
  localparam logic [KEY_W-1:0] ID_ONES = '1;
  // Key base for the table-full test, clear of the directed ids.
  localparam logic [KEY_W-1:0] FILL_BASE = 64'hA5A5_0000_0000_0000;

  localparam int POOL_SIZE = 96;   // more ids than slots, so the table can fill up
  // Worst case per request: sender gap, the token walk and a long sink stall,
  // taken several times over.
  localparam int CYCLE_LIMIT = 1_500_000;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [KEY_W-1:0]   block_id;
    logic [RES_W-1:0]   initial_residency;
    logic               location;
    logic [STAMP_W-1:0] now_stamp;
  } request_t;

  typedef struct packed {
    logic [STS_W-1:0]   status;
    logic [RES_W-1:0]   residency;
    logic [STAMP_W-1:0] last_stamp;
    logic [HITS_W-1:0]  hit_count;
  } entry_view_t;

  logic clk;
  logic rst_n;

  brt_in_if  in_ch();
  brt_out_if out_ch();

  block_residency_table_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Local copy of the table, updated at each request accept.
  logic               tbl_valid [BRT_ENTRIES];
  logic [KEY_W-1:0]   tbl_key   [BRT_ENTRIES];
  logic [RES_W-1:0]   tbl_where [BRT_ENTRIES];
  logic [STAMP_W-1:0] tbl_stamp [BRT_ENTRIES];
  logic [HITS_W-1:0]  tbl_hits  [BRT_ENTRIES];

  entry_view_t      pending_results[$];
  logic [KEY_W-1:0] id_pool[POOL_SIZE];

  int err_count;
  int cycle_count;
  int sink_stall;
  bit idle_on;

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Gap length for either side: mostly none or short, now and then long.
  function automatic int pick_gap();
    int p;
    if (!idle_on) return 0;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 85) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 16);
    return $urandom_range(30, 120);
  endfunction

  // Stamps: bias toward both extremes, otherwise anything.
  function automatic logic [STAMP_W-1:0] pick_stamp();
    int p;
    p = $urandom_range(0, 9);
    if (p == 0) return '0;
    if (p == 1) return '1;
    return $urandom;
  endfunction

  // Apply one request to the local table and return the result it must give.
  // Promote sets the target's bit in the residency code, demote clears it.
  function automatic entry_view_t apply_request(request_t r);
    int               hit;
    int               slot;
    logic [RES_W-1:0] loc_bit;
    entry_view_t      v;
    hit = -1;
    for (int i = 0; i < BRT_ENTRIES; i++) begin
      if (hit < 0 && tbl_valid[i] && tbl_key[i] == r.block_id) hit = i;
    end
    v.status     = STS_MISS;
    v.residency  = RES_DISK;
    v.last_stamp = '0;
    v.hit_count  = '0;
    loc_bit = r.location ? RES_GPU : RES_CPU;

    if (r.kind == KIND_REGISTER) begin
      slot = hit;
      for (int i = 0; i < BRT_ENTRIES; i++) begin
        if (slot < 0 && !tbl_valid[i]) slot = i;
      end
      if (slot < 0) begin
        v.status = STS_FULL;
        return v;
      end
      tbl_valid[slot] = 1'b1;
      tbl_key[slot]   = r.block_id;
      tbl_where[slot] = r.initial_residency;
      tbl_stamp[slot] = r.now_stamp;
      tbl_hits[slot]  = '0;
    end else begin
      if (hit < 0) return v;
      slot = hit;
      case (r.kind)
        KIND_UNREGISTER: begin
          tbl_valid[slot] = 1'b0;
          v.status = STS_OK;
          return v;
        end
        KIND_PROMOTE: tbl_where[slot] = tbl_where[slot] | loc_bit;
        KIND_DEMOTE:  tbl_where[slot] = tbl_where[slot] & ~loc_bit;
        KIND_TOUCH: begin
          tbl_stamp[slot] = r.now_stamp;
          if (tbl_hits[slot] != '1) tbl_hits[slot] = tbl_hits[slot] + 1'b1;
        end
        default: ;
      endcase
    end
    v.status     = STS_OK;
    v.residency  = tbl_where[slot];
    v.last_stamp = tbl_stamp[slot];
    v.hit_count  = tbl_hits[slot];
    return v;
  endfunction

  // Send one request. Entered and left just after a falling edge; valid stays
  // high into the next request when there is no gap.
  task automatic send_request(input logic [KIND_W-1:0] kind,
                              input logic [KEY_W-1:0] id,
                              input logic [RES_W-1:0] init_res,
                              input logic loc,
                              input logic [STAMP_W-1:0] stamp);
    int       gap;
    request_t r;
    r.kind              = kind;
    r.block_id          = id;
    r.initial_residency = init_res;
    r.location          = loc;
    r.now_stamp         = stamp;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.kind              = r.kind;
    in_ch.block_id          = r.block_id;
    in_ch.initial_residency = r.initial_residency;
    in_ch.location          = r.location;
    in_ch.now_stamp         = r.now_stamp;
    in_ch.valid             = 1'b1;
    // Hold the request until the block takes it.
    forever begin
      @(posedge clk);
      if (in_ch.ready) break;
    end
    pending_results.push_back(apply_request(r));
    @(negedge clk);
  endtask

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (want !== got) begin
      err_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endfunction

  // Drive the sink's ready: random stalls of the same shape as sender gaps.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready = 1'b0;
    end else if (sink_stall > 0) begin
      out_ch.ready = 1'b0;
      sink_stall--;
    end else begin
      sink_stall = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
      out_ch.ready = (sink_stall == 0);
      if (sink_stall > 0) sink_stall--;
    end
  end

  // Match every accepted result against the oldest prediction.
  always @(posedge clk) begin
    entry_view_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        err_count++;
        $display("%0t: unexpected result, expected none, actual sts %0h res %0h stamp %0h hits %0h",
                 $time, out_ch.status, out_ch.residency, out_ch.last_stamp, out_ch.hit_count);
      end else begin
        want = pending_results.pop_front();
        check_field("status",     64'(want.status),     64'(out_ch.status));
        check_field("residency",  64'(want.residency),  64'(out_ch.residency));
        check_field("last_stamp", 64'(want.last_stamp), 64'(out_ch.last_stamp));
        check_field("hit_count",  64'(want.hit_count),  64'(out_ch.hit_count));
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Misses on an empty table, both extreme ids, every residency transition,
  // touch, both queries, overwrite, the spare kind and unregister.
  task automatic test_directed();
    idle_on = 1'b1;
    // every named non-register kind on an id that is not there
    send_request(KIND_RES_QUERY,  ID_ZERO, RES_DISK, 1'b0, '0);
    send_request(KIND_UNREGISTER, ID_ZERO, RES_DISK, 1'b0, '0);
    send_request(KIND_PROMOTE,    ID_ONES, RES_DISK, 1'b1, '0);
    send_request(KIND_DEMOTE,     ID_ONES, RES_DISK, 1'b0, '0);
    send_request(KIND_TOUCH,      ID_ZERO, RES_DISK, 1'b0, '1);
    send_request(KIND_INFO_QUERY, ID_ONES, RES_DISK, 1'b0, '0);
    // extreme ids and stamps
    send_request(KIND_REGISTER,   ID_ZERO, RES_DISK, 1'b0, '0);
    send_request(KIND_REGISTER,   ID_ONES, RES_BOTH, 1'b1, '1);
    // walk id zero through every transition: disk, gpu, both, cpu, disk, ...
    send_request(KIND_PROMOTE,    ID_ZERO, RES_DISK, 1'b1, '0);
    send_request(KIND_PROMOTE,    ID_ZERO, RES_DISK, 1'b0, '0);
    send_request(KIND_DEMOTE,     ID_ZERO, RES_DISK, 1'b1, '0);
    send_request(KIND_DEMOTE,     ID_ZERO, RES_DISK, 1'b0, '0);
    send_request(KIND_PROMOTE,    ID_ZERO, RES_DISK, 1'b0, '0);
    send_request(KIND_PROMOTE,    ID_ZERO, RES_DISK, 1'b1, '0);
    send_request(KIND_DEMOTE,     ID_ZERO, RES_DISK, 1'b0, '0);
    send_request(KIND_DEMOTE,     ID_ZERO, RES_DISK, 1'b1, '0);
    // demote from disk keeps disk
    send_request(KIND_DEMOTE,     ID_ZERO, RES_DISK, 1'b1, '0);
    send_request(KIND_TOUCH,      ID_ZERO, RES_DISK, 1'b0, 32'h8000_0001);
    send_request(KIND_TOUCH,      ID_ZERO, RES_DISK, 1'b0, '1);
    send_request(KIND_INFO_QUERY, ID_ZERO, RES_DISK, 1'b0, '0);
    send_request(KIND_RES_QUERY,  ID_ONES, RES_DISK, 1'b0, '0);
    // overwrite clears the count
    send_request(KIND_REGISTER,   ID_ZERO, RES_GPU,  1'b0, 32'h0000_1234);
    send_request(KIND_SPARE,      ID_ZERO, RES_DISK, 1'b0, '0);
    send_request(KIND_UNREGISTER, ID_ONES, RES_DISK, 1'b0, '0);
    send_request(KIND_INFO_QUERY, ID_ONES, RES_DISK, 1'b0, '0);
  endtask

  // Fill every slot, register into the full table, overwrite while full,
  // free one slot and refill it, then empty the table again.
  // Count saturation needs ~4e9 touches of one id and is out of reach here.
  task automatic test_table_full();
    int               live;
    logic [KEY_W-1:0] drop_ids[$];
    idle_on = 1'b1;
    live = 0;
    for (int i = 0; i < BRT_ENTRIES; i++) if (tbl_valid[i]) live++;
    for (int i = 0; live < BRT_ENTRIES; i++) begin
      send_request(KIND_REGISTER, FILL_BASE | KEY_W'(i), RES_W'($urandom_range(0, 3)), 1'b0,
                   pick_stamp());
      live++;
    end
    send_request(KIND_REGISTER, FILL_BASE | 64'hFFFF, RES_CPU, 1'b0, pick_stamp());
    send_request(KIND_REGISTER, FILL_BASE | 64'd3, RES_BOTH, 1'b0, pick_stamp());
    send_request(KIND_TOUCH, FILL_BASE | 64'd3, RES_DISK, 1'b0, pick_stamp());
    send_request(KIND_UNREGISTER, FILL_BASE | 64'd10, RES_DISK, 1'b0, '0);
    send_request(KIND_REGISTER, FILL_BASE | 64'hFFFF, RES_GPU, 1'b0, pick_stamp());
    send_request(KIND_INFO_QUERY, FILL_BASE | 64'hFFFF, RES_DISK, 1'b0, '0);
    send_request(KIND_REGISTER, FILL_BASE | 64'hFFFE, RES_GPU, 1'b0, pick_stamp());
    // drop every live id; the table is known to be empty afterward
    for (int i = 0; i < BRT_ENTRIES; i++) if (tbl_valid[i]) drop_ids.push_back(tbl_key[i]);
    foreach (drop_ids[i]) send_request(KIND_UNREGISTER, drop_ids[i], RES_DISK, 1'b0, '0);
  endtask

  // Random traffic over a pool of ids, two thirds of which differ from a common
  // base by one bit, so the key compare sees near misses. A quarter of the
  // requests use a fresh fully random id, which almost always misses.
  task automatic test_random_traffic(input int count, input int reg_pct,
                                     input int unreg_pct, input bit with_idle);
    int                p;
    int                q;
    logic [KIND_W-1:0] kind;
    logic [KEY_W-1:0]  id;
    idle_on = with_idle;
    for (int n = 0; n < count; n++) begin
      p = $urandom_range(0, 99);
      q = $urandom_range(0, 11);
      if (p < reg_pct) kind = KIND_REGISTER;
      else if (p < reg_pct + unreg_pct) kind = KIND_UNREGISTER;
      else if (q < 3) kind = KIND_PROMOTE;
      else if (q < 6) kind = KIND_DEMOTE;
      else if (q < 8) kind = KIND_RES_QUERY;
      else if (q < 10) kind = KIND_TOUCH;
      else if (q < 11) kind = KIND_INFO_QUERY;
      else kind = KIND_SPARE;
      if ($urandom_range(0, 3) != 0) id = id_pool[$urandom_range(0, POOL_SIZE - 1)];
      else id = {$urandom, $urandom};
      send_request(kind, id, RES_W'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                   pick_stamp());
    end
  endtask

  initial begin
    logic [KEY_W-1:0] base;
    clk         = 1'b0;
    rst_n       = 1'b0;
    err_count   = 0;
    cycle_count = 0;
    sink_stall  = 0;
    idle_on     = 1'b1;
    in_ch.valid             = 1'b0;
    in_ch.kind              = KIND_REGISTER;
    in_ch.block_id          = '0;
    in_ch.initial_residency = RES_DISK;
    in_ch.location          = 1'b0;
    in_ch.now_stamp         = '0;
    out_ch.ready            = 1'b0;
    for (int i = 0; i < BRT_ENTRIES; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_key[i]   = '0;
      tbl_where[i] = RES_DISK;
      tbl_stamp[i] = '0;
      tbl_hits[i]  = '0;
    end
    base = {$urandom, $urandom};
    for (int i = 0; i < POOL_SIZE; i++) begin
      id_pool[i] = (i < KEY_W) ? (base ^ (64'd1 << i)) : {$urandom, $urandom};
    end

    // hold reset, then release it on a falling edge
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_table_full();
    test_random_traffic(500, 35, 8, 1'b1);    // fill-heavy, drives the table to full
    test_random_traffic(300, 20, 15, 1'b0);   // back-to-back stretch, no idling
    test_random_traffic(500, 15, 30, 1'b1);   // drain-heavy

    @(negedge clk);
    in_ch.valid = 1'b0;
    idle_on = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    // allow one more token walk for a stray result
    repeat (BRT_ENTRIES + 8) @(posedge clk);

    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/brt_pkg.sv
hw/rtl/brt_if.sv
hw/rtl/brt_cell.sv
hw/rtl/block_residency_table_top.sv
bench/block_residency_table_top_tb.sv
